// ----- rtl/core/iee_pkg.sv -----
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants for the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int unsigned OPND_DEPTH = 64;
    localparam int unsigned OPR_DEPTH  = 64;
    localparam int unsigned OPND_AW    = $clog2(OPND_DEPTH);
    localparam int unsigned OPR_AW     = $clog2(OPR_DEPTH);

    typedef enum logic [2:0] {
        OPC_ADD  = 3'd0,
        OPC_SUB  = 3'd1,
        OPC_MUL  = 3'd2,
        OPC_DIV  = 3'd3,
        OPC_POW  = 3'd4,
        OPC_LPAR = 3'd5
    } opc_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNTAX   = 2'd1,
        ST_DIVZERO  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    // arithmetic unit request / response
    typedef struct packed {
        logic        start;
        opc_t        op;
        logic [63:0] a;
        logic [63:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic        div_zero;
        logic [63:0] result;
    } alu_rsp_t;

endpackage

// ----- rtl/core/iee_ram.sv -----
// ----------------------------------------------------------------------------
// iee_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module iee_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/core/iee_alu.sv -----
// ----------------------------------------------------------------------------
// iee_alu
// Multi-cycle 64-bit arithmetic: add/sub at the request, multiply as three
// 32x32 partial products, signed restoring divide (one bit a cycle),
// power by square-and-multiply over the multiplier.
// ----------------------------------------------------------------------------
module iee_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  iee_pkg::alu_req_t req,
    output iee_pkg::alu_rsp_t rsp
);
    import iee_pkg::*;

    typedef enum logic [6:0] {
        A_IDLE = 7'b0000001,
        A_MUL  = 7'b0000010,
        A_DIV  = 7'b0000100,
        A_PSQ  = 7'b0001000,
        A_PML  = 7'b0010000,
        A_PWT  = 7'b0100000,
        A_DONE = 7'b1000000
    } astate_t;

    astate_t     state_reg, state_next;
    logic [63:0] res_reg, res_next;
    logic        dz_reg, dz_next;
    logic [63:0] x_reg, x_next;      // multiplicand / power base / remainder
    logic [63:0] y_reg, y_next;      // multiplier / exponent / dividend
    logic [63:0] d_reg, d_next;      // divisor magnitude
    logic        qneg_reg, qneg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [1:0]  mph_reg, mph_next;
    logic [63:0] macc_reg, macc_next;
    logic [63:0] mul_a, mul_b;

    // multiplier: one 32x32 partial product a cycle, low 64 bits kept
    logic [31:0] pa, pb;
    logic [63:0] prod;
    always_comb begin
        pa = mph_reg[1] ? mul_a[63:32] : mul_a[31:0];
        pb = mph_reg[0] ? mul_b[63:32] : mul_b[31:0];
        prod = {32'd0, pa} * {32'd0, pb};
    end

    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    always_comb begin
        rem_sh  = {x_reg, y_reg[63]};
        rem_sub = rem_sh - {1'b0, d_reg};
    end

    always_comb begin
        state_next  = state_reg;
        res_next    = res_reg;
        dz_next     = dz_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        qneg_next   = qneg_reg;
        cnt_next    = cnt_reg;
        mph_next    = mph_reg;
        macc_next   = macc_reg;
        mul_a       = x_reg;
        mul_b       = y_reg;
        if (state_reg == A_PML) begin
            mul_a = res_reg;
            mul_b = x_reg;
        end else if (state_reg == A_PSQ) begin
            mul_a = x_reg;
            mul_b = x_reg;
        end
        unique case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    dz_next  = 1'b0;
                    mph_next = 2'd0;
                    macc_next = 64'd0;
                    unique case (req.op)
                        OPC_ADD: begin
                            res_next   = req.a + req.b;
                            state_next = A_DONE;
                        end
                        OPC_SUB: begin
                            res_next   = req.a - req.b;
                            state_next = A_DONE;
                        end
                        OPC_MUL: begin
                            x_next     = req.a;
                            y_next     = req.b;
                            state_next = A_MUL;
                        end
                        OPC_DIV: begin
                            if (req.b == 64'd0) begin
                                dz_next    = 1'b1;
                                state_next = A_DONE;
                            end else begin
                                x_next    = 64'd0;
                                y_next    = req.a[63] ? (64'd0 - req.a) : req.a;
                                d_next    = req.b[63] ? (64'd0 - req.b) : req.b;
                                qneg_next = req.a[63] ^ req.b[63];
                                cnt_next  = 7'd64;
                                state_next = A_DIV;
                            end
                        end
                        OPC_POW: begin
                            if (req.b[63]) begin
                                state_next = A_DONE;
                                if (req.a == 64'd1) begin
                                    res_next = 64'd1;
                                end else if (req.a == '1) begin
                                    res_next = req.b[0] ? '1 : 64'd1;
                                end else if (req.a == 64'd0) begin
                                    dz_next = 1'b1;
                                end else begin
                                    res_next = 64'd0;
                                end
                            end else begin
                                res_next   = 64'd1;
                                x_next     = req.a;
                                y_next     = req.b;
                                state_next = A_PWT;
                            end
                        end
                        default: begin
                            res_next   = 64'd0;
                            state_next = A_DONE;
                        end
                    endcase
                end
            end
            A_MUL: begin
                // phases: lo*lo, lo*hi, hi*lo (hi*hi drops out of 64 bits)
                unique case (mph_reg)
                    2'd0: macc_next = macc_reg + prod;
                    2'd1, 2'd2: macc_next = macc_reg + {prod[31:0], 32'd0};
                    default: macc_next = macc_reg;
                endcase
                if (mph_reg == 2'd2) begin
                    res_next   = macc_reg + {prod[31:0], 32'd0};
                    mph_next   = 2'd0;
                    state_next = A_DONE;
                end else begin
                    mph_next = mph_reg + 2'd1;
                end
            end
            A_DIV: begin
                if (!rem_sub[64]) begin
                    x_next = rem_sub[63:0];
                    y_next = {y_reg[62:0], 1'b1};
                end else begin
                    x_next = rem_sh[63:0];
                    y_next = {y_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    res_next   = qneg_reg ? (64'd0 - y_next) : y_next;
                    state_next = A_DONE;
                end
            end
            A_PWT: begin
                macc_next = 64'd0;
                mph_next  = 2'd0;
                if (y_reg == 64'd0) begin
                    state_next = A_DONE;
                end else if (y_reg[0]) begin
                    state_next = A_PML;
                end else begin
                    state_next = A_PSQ;
                end
            end
            A_PML: begin
                unique case (mph_reg)
                    2'd0: macc_next = macc_reg + prod;
                    2'd1, 2'd2: macc_next = macc_reg + {prod[31:0], 32'd0};
                    default: macc_next = macc_reg;
                endcase
                if (mph_reg == 2'd2) begin
                    res_next   = macc_reg + {prod[31:0], 32'd0};
                    macc_next  = 64'd0;
                    mph_next   = 2'd0;
                    state_next = A_PSQ;
                end else begin
                    mph_next = mph_reg + 2'd1;
                end
            end
            A_PSQ: begin
                unique case (mph_reg)
                    2'd0: macc_next = macc_reg + prod;
                    2'd1, 2'd2: macc_next = macc_reg + {prod[31:0], 32'd0};
                    default: macc_next = macc_reg;
                endcase
                if (mph_reg == 2'd2) begin
                    x_next     = macc_reg + {prod[31:0], 32'd0};
                    y_next     = {1'b0, y_reg[63:1]};
                    state_next = A_PWT;
                end else begin
                    mph_next = mph_reg + 2'd1;
                end
            end
            A_DONE: begin
                state_next = A_IDLE;
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= A_IDLE;
        end else begin
            state_reg  <= state_next;
        end
        res_reg  <= res_next;
        dz_reg   <= dz_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        d_reg    <= d_next;
        qneg_reg <= qneg_next;
        cnt_reg  <= cnt_next;
        mph_reg  <= mph_next;
        macc_reg <= macc_next;
    end

    assign rsp.done     = (state_reg == A_DONE);
    assign rsp.div_zero = dz_reg;
    assign rsp.result   = res_reg;
endmodule

// ----- rtl/core/infix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Shunting-yard integer calculator: operand and operator stacks in RAMs.
// A digit or skipped byte is accepted (S_IDLE) and dispatched (S_DISP);
// ending a number revisits S_DISP. An operator may reduce first: each
// reduction reads two operands, waits for the ALU and pushes the result.
// One request at a time; results leave through an output register.
// aresetn (synchronous) empties both stacks and clears number and error state.
// ----------------------------------------------------------------------------
module infix_expression_evaluator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // end_of_expression
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [1:0]  m_tuser    // [1:0] status
);
    import iee_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DISP   = 11'b00000000010,
        S_OPRRD  = 11'b00000000100,
        S_OPRCHK = 11'b00000001000,
        S_RDB    = 11'b00000010000,
        S_RDA    = 11'b00000100000,
        S_ALU    = 11'b00001000000,
        S_PUSHR  = 11'b00010000000,
        S_PUSHOP = 11'b00100000000,
        S_FINAL  = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    // what the reduction loop is serving
    typedef enum logic [3:0] {
        M_RPAR = 4'b0001,
        M_ADD  = 4'b0010,
        M_MUL  = 4'b0100,
        M_END  = 4'b1000
    } mode_t;

    state_t      state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [7:0]  ch_reg, ch_next;
    logic        last_reg, last_next;
    logic [OPND_AW:0] ocnt_reg, ocnt_next;
    logic [OPR_AW:0]  pcnt_reg, pcnt_next;
    logic [63:0] acc_reg, acc_next;
    logic        innum_reg, innum_next;
    logic        neg_reg, neg_next;
    logic        expo_reg, expo_next;
    status_t     err_reg, err_next;
    opc_t        pend_reg, pend_next;
    opc_t        top_reg, top_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] a_reg, a_next;
    logic        mval_reg, mval_next;
    logic [63:0] mdata_reg, mdata_next;
    logic [1:0]  muser_reg, muser_next;

    logic                od_we, pr_we;
    logic [OPND_AW-1:0]  od_addr;
    logic [OPR_AW-1:0]   pr_addr;
    logic [63:0]         od_wdata, od_rdata;
    logic [2:0]          pr_wdata, pr_rdata;
    alu_req_t            areq;
    alu_rsp_t            arsp;
    logic                alu_busy_reg, alu_busy_next;

    iee_ram #(.WIDTH(64), .DEPTH(OPND_DEPTH)) u_opnd (
        .aclk(aclk), .we(od_we), .addr(od_addr), .wdata(od_wdata), .rdata(od_rdata)
    );
    iee_ram #(.WIDTH(3), .DEPTH(OPR_DEPTH)) u_opr (
        .aclk(aclk), .we(pr_we), .addr(pr_addr), .wdata(pr_wdata), .rdata(pr_rdata)
    );
    iee_alu u_alu (.aclk(aclk), .aresetn(aresetn), .req(areq), .rsp(arsp));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    logic is_digit;
    logic ocnt_full, pcnt_full;
    logic [63:0] fin_val;
    assign is_digit  = (ch_reg >= CH_0) && (ch_reg <= CH_9);
    assign ocnt_full = (ocnt_reg >= (OPND_AW+1)'(OPND_DEPTH));
    assign pcnt_full = (pcnt_reg >= (OPR_AW+1)'(OPR_DEPTH));
    assign fin_val   = neg_reg ? (64'd0 - acc_reg) : acc_reg;

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        ch_next       = ch_reg;
        last_next     = last_reg;
        ocnt_next     = ocnt_reg;
        pcnt_next     = pcnt_reg;
        acc_next      = acc_reg;
        innum_next    = innum_reg;
        neg_next      = neg_reg;
        expo_next     = expo_reg;
        err_next      = err_reg;
        pend_next     = pend_reg;
        top_next      = top_reg;
        b_next        = b_reg;
        a_next        = a_reg;
        mval_next     = mval_reg;
        mdata_next    = mdata_reg;
        muser_next    = muser_reg;
        alu_busy_next = alu_busy_reg;
        od_we    = 1'b0;
        od_addr  = ocnt_reg[OPND_AW-1:0];
        od_wdata = fin_val;
        pr_we    = 1'b0;
        pr_addr  = pcnt_reg[OPR_AW-1:0];
        pr_wdata = pend_reg;
        areq.start = 1'b0;
        areq.op    = top_reg;
        areq.a     = a_reg;
        areq.b     = b_reg;

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ch_next    = s_tdata;
                    last_next  = s_tlast;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                state_next = S_IDLE;
                if (err_reg != ST_OK) begin
                    if (last_reg) begin
                        state_next = S_FINAL;
                    end
                end else if (!last_reg && is_digit) begin
                    acc_next   = (innum_reg ? ((acc_reg << 3) + (acc_reg << 1)) : 64'd0)
                                 + {60'd0, ch_reg[3:0]};
                    innum_next = 1'b1;
                end else if (innum_reg) begin
                    // finish pending number, then revisit this byte
                    innum_next = 1'b0;
                    neg_next   = 1'b0;
                    expo_next  = 1'b0;
                    acc_next   = 64'd0;
                    if (ocnt_full) begin
                        err_next = ST_OVERFLOW;
                    end else begin
                        od_we     = 1'b1;
                        ocnt_next = ocnt_reg + 1'b1;
                    end
                    state_next = S_DISP;
                end else if (last_reg) begin
                    mode_next  = M_END;
                    state_next = S_OPRRD;
                end else begin
                    priority if (ch_reg == CH_LPAR) begin
                        neg_next   = 1'b0;
                        pend_next  = OPC_LPAR;
                        expo_next  = 1'b1;
                        state_next = S_PUSHOP;
                    end else if (ch_reg == CH_RPAR) begin
                        neg_next   = 1'b0;
                        mode_next  = M_RPAR;
                        state_next = S_OPRRD;
                    end else if (ch_reg == CH_MINUS && expo_reg) begin
                        neg_next = 1'b1;
                    end else if (ch_reg == CH_MINUS || ch_reg == CH_PLUS) begin
                        neg_next   = 1'b0;
                        pend_next  = (ch_reg == CH_PLUS) ? OPC_ADD : OPC_SUB;
                        mode_next  = M_ADD;
                        state_next = S_OPRRD;
                    end else if (ch_reg == CH_STAR || ch_reg == CH_SLASH) begin
                        neg_next   = 1'b0;
                        pend_next  = (ch_reg == CH_STAR) ? OPC_MUL : OPC_DIV;
                        mode_next  = M_MUL;
                        state_next = S_OPRRD;
                    end else if (ch_reg == CH_CARET) begin
                        neg_next   = 1'b0;
                        pend_next  = OPC_POW;
                        state_next = S_PUSHOP;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OPRRD: begin
                pr_addr = pcnt_reg[OPR_AW-1:0] - 1'b1;
                if (pcnt_reg == '0) begin
                    unique case (mode_reg)
                        M_RPAR: begin
                            err_next   = ST_SYNTAX;
                            state_next = S_IDLE;
                        end
                        M_END:   state_next = S_FINAL;
                        default: state_next = S_PUSHOP;
                    endcase
                end else begin
                    state_next = S_OPRCHK;
                end
            end
            S_OPRCHK: begin
                top_next = opc_t'(pr_rdata);
                unique case (mode_reg)
                    M_RPAR: begin
                        pcnt_next = pcnt_reg - 1'b1;
                        if (opc_t'(pr_rdata) == OPC_LPAR) begin
                            expo_next  = 1'b0;
                            state_next = S_IDLE;
                        end else begin
                            state_next = S_RDB;
                        end
                    end
                    M_ADD: begin
                        if (opc_t'(pr_rdata) == OPC_LPAR) begin
                            state_next = S_PUSHOP;
                        end else begin
                            pcnt_next  = pcnt_reg - 1'b1;
                            state_next = S_RDB;
                        end
                    end
                    M_MUL: begin
                        if (opc_t'(pr_rdata) == OPC_MUL || opc_t'(pr_rdata) == OPC_DIV
                            || opc_t'(pr_rdata) == OPC_POW) begin
                            pcnt_next  = pcnt_reg - 1'b1;
                            state_next = S_RDB;
                        end else begin
                            state_next = S_PUSHOP;
                        end
                    end
                    default: begin
                        pcnt_next  = pcnt_reg - 1'b1;
                        state_next = S_RDB;
                    end
                endcase
            end
            S_RDB: begin
                od_addr = ocnt_reg[OPND_AW-1:0] - 1'b1;
                if (top_reg == OPC_LPAR || ocnt_reg < (OPND_AW+1)'(2)) begin
                    err_next   = ST_SYNTAX;
                    state_next = (mode_reg == M_END) ? S_FINAL : S_IDLE;
                end else begin
                    state_next = S_RDA;
                end
            end
            S_RDA: begin
                od_addr    = ocnt_reg[OPND_AW-1:0] - 2'd2;
                b_next     = od_rdata;
                state_next = S_ALU;
            end
            S_ALU: begin
                if (!alu_busy_reg) begin
                    areq.start    = 1'b1;
                    areq.a        = od_rdata;
                    a_next        = od_rdata;
                    ocnt_next     = ocnt_reg - 2'd2;
                    alu_busy_next = 1'b1;
                end else if (arsp.done) begin
                    alu_busy_next = 1'b0;
                    a_next        = arsp.result;
                    if (arsp.div_zero) begin
                        err_next   = ST_DIVZERO;
                        state_next = (mode_reg == M_END) ? S_FINAL : S_IDLE;
                    end else begin
                        state_next = S_PUSHR;
                    end
                end
            end
            S_PUSHR: begin
                od_wdata = a_reg;
                if (ocnt_full) begin
                    err_next   = ST_OVERFLOW;
                    state_next = (mode_reg == M_END) ? S_FINAL : S_IDLE;
                end else begin
                    od_we      = 1'b1;
                    ocnt_next  = ocnt_reg + 1'b1;
                    state_next = S_OPRRD;
                end
            end
            S_PUSHOP: begin
                if (pcnt_full) begin
                    err_next = ST_OVERFLOW;
                end else begin
                    pr_we     = 1'b1;
                    pcnt_next = pcnt_reg + 1'b1;
                end
                expo_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_FINAL: begin
                od_addr = '0;
                if (err_reg == ST_OK && ocnt_reg != (OPND_AW+1)'(1)) begin
                    err_next = ST_SYNTAX;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                od_addr = '0;
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdata_next = (err_reg == ST_OK) ? od_rdata : 64'd0;
                    muser_next = err_reg;
                    ocnt_next  = '0;
                    pcnt_next  = '0;
                    acc_next   = 64'd0;
                    innum_next = 1'b0;
                    neg_next   = 1'b0;
                    expo_next  = 1'b1;
                    err_next   = ST_OK;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= M_END;
            ocnt_reg     <= '0;
            pcnt_reg     <= '0;
            acc_reg      <= 64'd0;
            innum_reg    <= 1'b0;
            neg_reg      <= 1'b0;
            expo_reg     <= 1'b1;
            err_reg      <= ST_OK;
            mval_reg     <= 1'b0;
            alu_busy_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            ocnt_reg     <= ocnt_next;
            pcnt_reg     <= pcnt_next;
            acc_reg      <= acc_next;
            innum_reg    <= innum_next;
            neg_reg      <= neg_next;
            expo_reg     <= expo_next;
            err_reg      <= err_next;
            mval_reg     <= mval_next;
            alu_busy_reg <= alu_busy_next;
        end
        ch_reg    <= ch_next;
        last_reg  <= last_next;
        pend_reg  <= pend_next;
        top_reg   <= top_next;
        b_reg     <= b_next;
        a_reg     <= a_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end
endmodule
